>>> sv/wh2d_pkg.sv
// shared types, sizes and register codes of the weighted 2d histogram unit
// no dependencies; every other file refers to this package by scoped names
package wh2d_pkg;

  localparam int MAX_X_BINS = 64;
  localparam int MAX_Y_BINS = 64;
  localparam int CELLS      = MAX_X_BINS * MAX_Y_BINS;

  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int BIN_X_W = (MAX_X_BINS > 1) ? $clog2(MAX_X_BINS) : 1;
  localparam int BIN_Y_W = (MAX_Y_BINS > 1) ? $clog2(MAX_Y_BINS) : 1;
  localparam int BIN_W   = (BIN_X_W > BIN_Y_W) ? BIN_X_W : BIN_Y_W;

  localparam int CNT_W      = 7;
  localparam int COORD_W    = 32;
  localparam int SCALE_W    = 32;
  localparam int WEIGHT_W   = 16;
  localparam int WSQ_W      = 32;
  localparam int SUM_W      = 48;
  localparam int CELL_W     = 12;
  localparam int RD_BIN_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_BIN_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BIN_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_BINS_USED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BINS_USED = 3'd5;

  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_origin;
    logic [SCALE_W-1:0]        x_bin_scale;
    logic [SCALE_W-1:0]        y_bin_scale;
    logic [CNT_W-1:0]          x_bins_used;
    logic [CNT_W-1:0]          y_bins_used;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  sum_sq;
  } st_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } st_rd_t;

endpackage

>>> sv/wh2d_cfg_regs.sv
// configuration register file of the weighted 2d histogram unit
// depends on wh2d_pkg for the register codes and the cfg_t bundle
module wh2d_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wh2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wh2d_pkg::CFG_DATA_W-1:0] cfg_data,
  output wh2d_pkg::cfg_t                  cfg
);

  wh2d_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin    <= '0;
      cfg_r.y_origin    <= '0;
      cfg_r.x_bin_scale <= wh2d_pkg::SCALE_W'(65536);
      cfg_r.y_bin_scale <= wh2d_pkg::SCALE_W'(65536);
      cfg_r.x_bins_used <= wh2d_pkg::CNT_W'(64);
      cfg_r.y_bins_used <= wh2d_pkg::CNT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wh2d_pkg::REG_X_ORIGIN:    cfg_r.x_origin    <= $signed(cfg_data);
        wh2d_pkg::REG_Y_ORIGIN:    cfg_r.y_origin    <= $signed(cfg_data);
        wh2d_pkg::REG_X_BIN_SCALE: cfg_r.x_bin_scale <= cfg_data;
        wh2d_pkg::REG_Y_BIN_SCALE: cfg_r.y_bin_scale <= cfg_data;
        wh2d_pkg::REG_X_BINS_USED: cfg_r.x_bins_used <= cfg_data[wh2d_pkg::CNT_W-1:0];
        wh2d_pkg::REG_Y_BINS_USED: cfg_r.y_bins_used <= cfg_data[wh2d_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/wh2d_locate.sv
// shared bin locator: one registered 32x32 multiply per coordinate
// depends on wh2d_pkg for widths; the top level feeds x then y through it
module wh2d_locate (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [wh2d_pkg::COORD_W:0]    delta,
  input  logic [wh2d_pkg::SCALE_W-1:0]         scale,
  input  logic [wh2d_pkg::CNT_W-1:0]           nbins,
  output logic [wh2d_pkg::BIN_W-1:0]           bin,
  output logic                                 ok
);

  logic [wh2d_pkg::COORD_W+wh2d_pkg::SCALE_W-1:0] prod;
  logic [wh2d_pkg::SCALE_W-1:0] hi_r;
  logic neg_r;
  logic zscale_r;

  assign prod = delta[wh2d_pkg::COORD_W-1:0] * scale;

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r     <= prod[wh2d_pkg::COORD_W+wh2d_pkg::SCALE_W-1:wh2d_pkg::COORD_W];
      neg_r    <= delta[wh2d_pkg::COORD_W];
      zscale_r <= (scale == '0);
    end
  end

  // a negative offset lands in bin 0 only with a zero scale
  always_comb begin
    if (neg_r) begin
      ok  = zscale_r && (nbins != '0);
      bin = '0;
    end else begin
      ok  = hi_r < wh2d_pkg::SCALE_W'(nbins);
      bin = hi_r[wh2d_pkg::BIN_W-1:0];
    end
  end

endmodule

>>> sv/wh2d_bin_store.sv
// per-bin sum and sum-of-squares memories with a clearing sweep after reset
// depends on wh2d_pkg for sizes and the read/write request bundles
module wh2d_bin_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wh2d_pkg::st_rd_t              rd,
  input  wh2d_pkg::st_wr_t              wr,
  output logic [wh2d_pkg::SUM_W-1:0]    rd_sum,
  output logic [wh2d_pkg::SUM_W-1:0]    rd_sum_sq,
  output logic                          ready
);

  logic [wh2d_pkg::SUM_W-1:0] sum_mem    [wh2d_pkg::CELLS];
  logic [wh2d_pkg::SUM_W-1:0] sum_sq_mem [wh2d_pkg::CELLS];
  logic [wh2d_pkg::SUM_W-1:0] rd_sum_r;
  logic [wh2d_pkg::SUM_W-1:0] rd_sum_sq_r;

  logic                        clearing_r;
  logic [wh2d_pkg::ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == wh2d_pkg::ADDR_W'(wh2d_pkg::CELLS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      sum_mem[clr_addr_r]    <= '0;
      sum_sq_mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      sum_mem[wr.addr]    <= wr.sum;
      sum_sq_mem[wr.addr] <= wr.sum_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_sum_r    <= sum_mem[rd.addr];
      rd_sum_sq_r <= sum_sq_mem[rd.addr];
    end
  end

  assign rd_sum    = rd_sum_r;
  assign rd_sum_sq = rd_sum_sq_r;
  assign ready     = !clearing_r;

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !wr.en)
    else $error("store written during clearing sweep");

  a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !rd.en)
    else $error("store read during clearing sweep");

  a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> $past(clr_addr_r) == wh2d_pkg::ADDR_W'(wh2d_pkg::CELLS - 1))
    else $error("clearing sweep ended early");

endmodule

>>> sv/weighted_2d_histogram_unit.sv
// top level of the weighted 2d histogram unit: request sequencer and output register
// depends on wh2d_pkg, wh2d_cfg_regs, wh2d_locate and wh2d_bin_store
//
//   channel | direction | handshake          | beat contents
//   in_     | input     | in_valid/in_stall  | req_type, coord_x, coord_y, fill_weight,
//           |           |                    | read_col, read_row
//   out_    | output    | out_valid/out_stall| hit, cell_index, weight_total, weight_sq_total
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// a fill beat passes through ST_MX, ST_MY, ST_LY, ST_ADDR and ST_RD after the accepting
// edge, a read beat through ST_ADDR and ST_RD only, with the unit held meanwhile. the
// shared locate multiplier (x then y) and the registered memory read set these steps.
// after reset the stores are swept clear over all MAX_X_BINS * MAX_Y_BINS cells (4096)
// with in_stall high; configuration writes are taken during that time.
// one beat is in work at a time; a waiting result holds in the output register
// and the next beat may be accepted meanwhile, stalling only at write-back.
module weighted_2d_histogram_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_req_type,
  input  logic signed [wh2d_pkg::COORD_W-1:0]    in_coord_x,
  input  logic signed [wh2d_pkg::COORD_W-1:0]    in_coord_y,
  input  logic signed [wh2d_pkg::WEIGHT_W-1:0]   in_fill_weight,
  input  logic [wh2d_pkg::RD_BIN_W-1:0]          in_read_col,
  input  logic [wh2d_pkg::RD_BIN_W-1:0]          in_read_row,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic [wh2d_pkg::CELL_W-1:0]            out_cell_index,
  output logic signed [wh2d_pkg::SUM_W-1:0]      out_weight_total,
  output logic [wh2d_pkg::SUM_W-1:0]             out_weight_sq_total,
  input  logic                                   cfg_we,
  input  logic [wh2d_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wh2d_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MX   = 3'd1;
  localparam logic [2:0] ST_MY   = 3'd2;
  localparam logic [2:0] ST_LY   = 3'd3;
  localparam logic [2:0] ST_ADDR = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;

  localparam int SW = wh2d_pkg::SUM_W;
  localparam int CW = wh2d_pkg::COORD_W;

  wh2d_pkg::cfg_t   cfg;
  wh2d_pkg::st_rd_t st_rd;
  wh2d_pkg::st_wr_t st_wr;

  logic [SW-1:0] rd_sum;
  logic [SW-1:0] rd_sum_sq;
  logic          st_ready;

  logic [2:0] state_r, state_nxt;

  logic                                 req_r;
  logic signed [CW:0]                   dx_r;
  logic signed [CW:0]                   dy_r;
  logic signed [wh2d_pkg::WEIGHT_W-1:0] w_r;
  logic [wh2d_pkg::WSQ_W-1:0]           wsq_r;
  logic [wh2d_pkg::BIN_X_W-1:0]         col_r;
  logic [wh2d_pkg::BIN_Y_W-1:0]         row_r;
  logic                                 xok_r;
  logic                                 yok_r;
  logic                                 hit_r;
  logic [wh2d_pkg::ADDR_W-1:0]          idx_r;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [wh2d_pkg::CELL_W-1:0] out_cell_index_r;
  logic signed [SW-1:0]        out_weight_total_r;
  logic [SW-1:0]               out_weight_sq_total_r;

  logic [wh2d_pkg::CNT_W-1:0]  nx;
  logic [wh2d_pkg::CNT_W-1:0]  ny;
  logic                        accept;
  logic                        out_free;
  logic                        retire;
  logic                        loc_en;
  logic signed [CW:0]          loc_delta;
  logic [wh2d_pkg::SCALE_W-1:0] loc_scale;
  logic [wh2d_pkg::CNT_W-1:0]  loc_nbins;
  logic [wh2d_pkg::BIN_W-1:0]  loc_bin;
  logic                        loc_ok;
  logic [wh2d_pkg::ADDR_W-1:0] idx;
  logic [SW:0]                 sum_ext;
  logic [SW:0]                 sq_ext;
  logic [SW-1:0]               sum_new;
  logic [SW-1:0]               sq_new;

  wh2d_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wh2d_locate u_locate (
    .clk   (clk),
    .en    (loc_en),
    .delta (loc_delta),
    .scale (loc_scale),
    .nbins (loc_nbins),
    .bin   (loc_bin),
    .ok    (loc_ok)
  );

  wh2d_bin_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (st_rd),
    .wr        (st_wr),
    .rd_sum    (rd_sum),
    .rd_sum_sq (rd_sum_sq),
    .ready     (st_ready)
  );

  // bin counts above the grid size act as the grid size
  assign nx = (32'(cfg.x_bins_used) > 32'(wh2d_pkg::MAX_X_BINS)) ?
              wh2d_pkg::CNT_W'(wh2d_pkg::MAX_X_BINS) : cfg.x_bins_used;
  assign ny = (32'(cfg.y_bins_used) > 32'(wh2d_pkg::MAX_Y_BINS)) ?
              wh2d_pkg::CNT_W'(wh2d_pkg::MAX_Y_BINS) : cfg.y_bins_used;

  assign in_stall = !((state_r == ST_IDLE) && st_ready);
  assign accept   = in_valid && !in_stall;
  assign out_free = !(out_valid_r && out_stall);
  assign retire   = (state_r == ST_RD) && out_free;

  // x goes through the multiplier in ST_MX, y in ST_MY; results are taken in the state that follows
  assign loc_en    = (state_r == ST_MX) || (state_r == ST_MY);
  assign loc_delta = (state_r == ST_MX) ? dx_r : dy_r;
  assign loc_scale = (state_r == ST_MX) ? cfg.x_bin_scale : cfg.y_bin_scale;
  assign loc_nbins = (state_r == ST_MY) ? nx : ny;

  assign idx = wh2d_pkg::ADDR_W'(row_r) * wh2d_pkg::ADDR_W'(nx)
             + wh2d_pkg::ADDR_W'(col_r);

  assign st_rd.en   = (state_r == ST_ADDR);
  assign st_rd.addr = (xok_r && yok_r) ? idx : '0;

  // saturating updates of the two sums
  assign sum_ext = {rd_sum[SW-1], rd_sum} + (SW+1)'(w_r);
  assign sq_ext  = {1'b0, rd_sum_sq} + (SW+1)'(wsq_r);

  always_comb begin
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_new = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_new = sum_ext[SW-1:0];
    end
    sq_new = sq_ext[SW] ? {SW{1'b1}} : sq_ext[SW-1:0];
  end

  assign st_wr.en     = retire && hit_r && (req_r == wh2d_pkg::REQ_FILL);
  assign st_wr.addr   = idx_r;
  assign st_wr.sum    = sum_new;
  assign st_wr.sum_sq = sq_new;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == wh2d_pkg::REQ_READ) ? ST_ADDR : ST_MX;
        end
      end
      ST_MX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_LY;
      ST_LY:   state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_RD;
      ST_RD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      dx_r  <= {in_coord_x[CW-1], in_coord_x} - {cfg.x_origin[CW-1], cfg.x_origin};
      dy_r  <= {in_coord_y[CW-1], in_coord_y} - {cfg.y_origin[CW-1], cfg.y_origin};
      w_r   <= in_fill_weight;
      wsq_r <= wh2d_pkg::WSQ_W'(in_fill_weight) * wh2d_pkg::WSQ_W'(in_fill_weight);
      col_r <= wh2d_pkg::BIN_X_W'(in_read_col);
      row_r <= wh2d_pkg::BIN_Y_W'(in_read_row);
      xok_r <= wh2d_pkg::CNT_W'(in_read_col) < nx;
      yok_r <= wh2d_pkg::CNT_W'(in_read_row) < ny;
    end else if (state_r == ST_MY) begin
      col_r <= wh2d_pkg::BIN_X_W'(loc_bin);
      xok_r <= loc_ok;
    end else if (state_r == ST_LY) begin
      row_r <= wh2d_pkg::BIN_Y_W'(loc_bin);
      yok_r <= loc_ok;
    end
    if (state_r == ST_ADDR) begin
      hit_r <= xok_r && yok_r;
      idx_r <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_hit_r        <= hit_r;
      out_cell_index_r <= hit_r ? wh2d_pkg::CELL_W'(idx_r) : '0;
      if (!hit_r) begin
        out_weight_total_r    <= '0;
        out_weight_sq_total_r <= '0;
      end else if (req_r == wh2d_pkg::REQ_FILL) begin
        out_weight_total_r    <= $signed(sum_new);
        out_weight_sq_total_r <= sq_new;
      end else begin
        out_weight_total_r    <= $signed(rd_sum);
        out_weight_sq_total_r <= rd_sum_sq;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_cell_index      = out_cell_index_r;
  assign out_weight_total    = out_weight_total_r;
  assign out_weight_sq_total = out_weight_sq_total_r;

  a_miss_never_writes: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |-> hit_r && (state_r == ST_RD))
    else $error("store written by a missed or misplaced beat");

  a_addr_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR) |=> (state_r == ST_RD))
    else $error("memory read not followed by its data cycle");

  a_retire_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not loaded at retire");

  a_no_accept_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !st_ready |-> in_stall)
    else $error("input accepted while stores are clearing");

endmodule
